/* hdl/bpfd_pkg.sv */
// Package for the bounded packet buffer with duplicate filter.
// Holds the sizes, operation codes and shared types. No dependencies.
package bpfd_pkg;

  localparam int ADDR_W = 10;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int CNT_W  = ADDR_W + 1;
  localparam int NODE_W = 20;
  localparam int TS_W   = 30;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_FWD = 2'd1;
  localparam logic [1:0] OP_CNT = 2'd2;

  typedef struct packed {
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic [TS_W-1:0]   ts;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } wr_req_t;

endpackage

/* hdl/bpfd_store.sv */
// Packet store: one write port and one read port with registered read data.
// Depends on bpfd_pkg.
module bpfd_store
  import bpfd_pkg::*;
(
  input  logic              clk,
  input  wr_req_t           wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/bounded_packet_fifo_with_dedup.sv */
// Bounded packet FIFO with duplicate filter: sequencer, compare unit and pointers.
// An add or count scans every stored packet through the single read port; a forward
// reads only the head entry, and an empty buffer or the unused code reads none. An
// output stall holds the result; a new operation is taken only after it is issued.
// Reset is synchronous, active low; it empties the buffer and sets the limit to 1024.
// Store contents are not cleared; only occupied slots are ever read. Needs bpfd_pkg, bpfd_store.
module bounded_packet_fifo_with_dedup
  import bpfd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [NODE_W-1:0] in_source,
  input  logic [NODE_W-1:0] in_destination,
  input  logic [TS_W-1:0]   in_timestamp,
  input  logic [TS_W-1:0]   in_start_time,
  input  logic [TS_W-1:0]   in_end_time,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_accepted,
  output logic              out_packet_valid,
  output logic [NODE_W-1:0] out_source,
  output logic [NODE_W-1:0] out_destination,
  output logic [TS_W-1:0]   out_timestamp,
  output logic [CNT_W-1:0]  out_match_count
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  limit_r, limit_nxt;
  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [ADDR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic [CNT_W-1:0]  issue_r, issue_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              hit_r, hit_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        op_r, op_nxt;
  entry_t            key_r, key_nxt;
  logic [TS_W-1:0]   t0_r, t0_nxt;
  logic [TS_W-1:0]   t1_r, t1_nxt;
  entry_t            fwd_r, fwd_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              acc_r, acc_nxt;
  logic              pv_r, pv_nxt;
  entry_t            pkt_r, pkt_nxt;
  logic [CNT_W-1:0]  mc_r, mc_nxt;

  logic [CNT_W-1:0]  limit_eff;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_data;
  wr_req_t           wr;
  logic              dup_hit;
  logic              cnt_hit;
  logic              in_fire;
  logic              out_free;

  bpfd_store u_store (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign limit_eff = (limit_r == '0) ? ONE_C : ((limit_r > DEPTH_C) ? DEPTH_C : limit_r);
  assign in_fire   = in_valid && (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign rd_en     = (state_r == S_SCAN) && (issue_r != total_r);
  assign rd_addr   = head_r + issue_r[ADDR_W-1:0];
  assign dup_hit   = (rd_data == key_r);
  assign cnt_hit   = (rd_data.dst == key_r.dst) && (rd_data.ts >= t0_r) &&
                     (rd_data.ts <= t1_r);

  always_comb begin
    state_nxt     = state_r;
    limit_nxt     = cfg_wr_en ? cfg_wr_data : limit_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    occ_nxt       = occ_r;
    issue_nxt     = issue_r;
    total_nxt     = total_r;
    rd_vld_nxt    = rd_en;
    hit_nxt       = hit_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    fwd_nxt       = fwd_r;
    out_valid_nxt = out_valid_r && out_stall;
    acc_nxt       = acc_r;
    pv_nxt        = pv_r;
    pkt_nxt       = pkt_r;
    mc_nxt        = mc_r;
    wr            = '0;

    if (rd_vld_r) begin
      fwd_nxt = rd_data;
      if (dup_hit) begin
        hit_nxt = 1'b1;
      end
      if (cnt_hit) begin
        cnt_nxt = cnt_r + ONE_C;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt    = in_operation;
          key_nxt   = '{src: in_source, dst: in_destination, ts: in_timestamp};
          t0_nxt    = in_start_time;
          t1_nxt    = in_end_time;
          issue_nxt = '0;
          hit_nxt   = 1'b0;
          cnt_nxt   = '0;
          case (in_operation)
            OP_ADD, OP_CNT: total_nxt = occ_r;
            OP_FWD:         total_nxt = (occ_r != '0) ? ONE_C : '0;
            default:        total_nxt = '0;
          endcase
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue_r == total_r) begin
          state_nxt = S_DONE;
        end else begin
          issue_nxt = issue_r + ONE_C;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          acc_nxt       = 1'b0;
          pv_nxt        = 1'b0;
          pkt_nxt       = '0;
          mc_nxt        = '0;
          case (op_r)
            OP_ADD: begin
              if (!hit_r) begin
                acc_nxt  = 1'b1;
                wr.en    = 1'b1;
                wr.addr  = tail_r;
                wr.data  = key_r;
                tail_nxt = tail_r + ADDR_W'(1);
                if (occ_r >= limit_eff) begin
                  head_nxt = head_r + ADDR_W'(1);
                end else begin
                  occ_nxt = occ_r + ONE_C;
                end
              end
            end
            OP_FWD: begin
              if (occ_r != '0) begin
                pv_nxt   = 1'b1;
                pkt_nxt  = fwd_r;
                head_nxt = head_r + ADDR_W'(1);
                occ_nxt  = occ_r - ONE_C;
              end
            end
            OP_CNT: begin
              mc_nxt = cnt_r;
            end
            default: begin
              mc_nxt = '0;
            end
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      limit_r     <= DEPTH_C;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      issue_r     <= '0;
      total_r     <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      limit_r     <= limit_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      issue_r     <= issue_nxt;
      total_r     <= total_nxt;
      rd_vld_r    <= rd_vld_nxt;
      hit_r       <= hit_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    key_r <= key_nxt;
    t0_r  <= t0_nxt;
    t1_r  <= t1_nxt;
    fwd_r <= fwd_nxt;
    acc_r <= acc_nxt;
    pv_r  <= pv_nxt;
    pkt_r <= pkt_nxt;
    mc_r  <= mc_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_accepted     = acc_r;
  assign out_packet_valid = pv_r;
  assign out_source       = pkt_r.src;
  assign out_destination  = pkt_r.dst;
  assign out_timestamp    = pkt_r.ts;
  assign out_match_count  = mc_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= DEPTH_C)
    else $error("Occupancy exceeds the store depth.");

  a_ptr_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r + occ_r[ADDR_W-1:0]) == tail_r)
    else $error("Head, tail and occupancy disagree.");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (issue_r <= total_r && total_r <= occ_r))
    else $error("Scan ran past the stored entries.");

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (!rd_vld_r && cnt_r <= total_r))
    else $error("Result formed before the scan finished.");

endmodule
